### src/trfp_pkg.sv
`timescale 1ns / 1ps

package trfp_pkg;

  localparam int FINGER_SLOTS = 5;
  localparam int RAW_SHIFT    = 11;  // raw span of 2048
  localparam int FRAME_LEN    = 1 + 4 * FINGER_SLOTS + 2;
  localparam int POS_W        = $clog2(FRAME_LEN);
  localparam int SLOT_W       = $clog2(FINGER_SLOTS);
  localparam int REC_BYTES    = 3;
  localparam int PART_W       = $clog2(REC_BYTES);
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int COORD_W      = 16;
  localparam int OUT_SLOT_W   = 3;

  localparam logic [7:0] MODE_RAW  = 8'h5A;
  localparam logic [7:0] EMPTY_B   = 8'hFF;
  localparam logic [7:0] HI_X_MASK = 8'hF0;
  localparam logic [7:0] HI_Y_MASK = 8'h0F;

  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_Y = 1'd1;

  localparam logic [CFG_W-1:0] PANEL_RESET = 12'd2047;

  typedef enum logic [1:0] {
    KIND_FINGER   = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_MODE_ERR = 2'd2,
    KIND_SUM_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_MODE_ERR,
    ST_SUM_ERR
  } state_t;

  typedef struct packed {
    logic  take_byte;
    logic  idx_clear;
    logic  idx_inc;
    logic  load_en;
    kind_t load_kind;
  } cmd_t;

  typedef struct packed {
    logic last_byte;
    logic mode_ok;
    logic sum_ok;
    logic rec_empty;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

### src/trfp_ctrl.sv
`timescale 1ns / 1ps

module trfp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  trfp_pkg::sts_t  sts,
  output trfp_pkg::cmd_t  cmd
);

  trfp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= trfp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      trfp_pkg::ST_IDLE: begin
        if (in_valid && sts.last_byte) begin
          if (!sts.mode_ok) begin
            state_nxt = trfp_pkg::ST_MODE_ERR;
          end else if (!sts.sum_ok) begin
            state_nxt = trfp_pkg::ST_SUM_ERR;
          end else begin
            state_nxt = trfp_pkg::ST_SCAN;
          end
        end
      end
      trfp_pkg::ST_SCAN: begin
        if (sts.idx_last && (sts.rec_empty || sts.out_free)) begin
          state_nxt = trfp_pkg::ST_DONE;
        end
      end
      trfp_pkg::ST_DONE, trfp_pkg::ST_MODE_ERR, trfp_pkg::ST_SUM_ERR: begin
        if (sts.out_free) begin
          state_nxt = trfp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = trfp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load_kind = trfp_pkg::KIND_FINGER;
    in_stall      = 1'b1;
    case (state_r)
      trfp_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.take_byte = in_valid;
        cmd.idx_clear = 1'b1;
      end
      trfp_pkg::ST_SCAN: begin
        // empty records are skipped without waiting on the output
        if (sts.rec_empty) begin
          cmd.idx_inc = 1'b1;
        end else if (sts.out_free) begin
          cmd.idx_inc = 1'b1;
          cmd.load_en = 1'b1;
        end
      end
      trfp_pkg::ST_DONE: begin
        cmd.load_en   = sts.out_free;
        cmd.load_kind = trfp_pkg::KIND_DONE;
      end
      trfp_pkg::ST_MODE_ERR: begin
        cmd.load_en   = sts.out_free;
        cmd.load_kind = trfp_pkg::KIND_MODE_ERR;
      end
      trfp_pkg::ST_SUM_ERR: begin
        cmd.load_en   = sts.out_free;
        cmd.load_kind = trfp_pkg::KIND_SUM_ERR;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  a_final_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en && cmd.load_kind != trfp_pkg::KIND_FINGER |=> state_r == trfp_pkg::ST_IDLE)
    else $error("final result did not return controller to idle");

  a_scan_after_good_frame: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == trfp_pkg::ST_IDLE && cmd.take_byte && sts.last_byte && sts.mode_ok &&
    sts.sum_ok |=> state_r == trfp_pkg::ST_SCAN)
    else $error("good frame did not start record scan");

  a_mode_checked_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_byte && sts.last_byte && !sts.mode_ok |=> state_r == trfp_pkg::ST_MODE_ERR)
    else $error("wrong mode not reported");

endmodule

### src/trfp_dp.sv
`timescale 1ns / 1ps

module trfp_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [7:0]                           in_data_byte,
  input  logic                                 in_frame_start,
  input  logic                                 cfg_we,
  input  logic [trfp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [trfp_pkg::CFG_W-1:0]           cfg_wdata,
  input  trfp_pkg::cmd_t                       cmd,
  output trfp_pkg::sts_t                       sts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_kind,
  output logic [trfp_pkg::OUT_SLOT_W-1:0]      out_slot,
  output logic [trfp_pkg::COORD_W-1:0]         out_pos_x,
  output logic [trfp_pkg::COORD_W-1:0]         out_pos_y,
  output logic                                 out_last
);

  localparam int PROD_W = 2 * trfp_pkg::CFG_W;

  logic [trfp_pkg::POS_W-1:0]  pos_r;
  logic [7:0]                  sum_r;
  logic [7:0]                  mode_r;
  logic [trfp_pkg::CFG_W-1:0]  pmx_r;
  logic [trfp_pkg::CFG_W-1:0]  pmy_r;
  logic [trfp_pkg::SLOT_W-1:0] idx_r;
  logic [7:0]                  rec_r [trfp_pkg::FINGER_SLOTS][trfp_pkg::REC_BYTES];

  logic                          out_valid_r;
  trfp_pkg::kind_t               kind_r;
  logic [trfp_pkg::OUT_SLOT_W-1:0] slot_r;
  logic [trfp_pkg::COORD_W-1:0]  pos_x_r;
  logic [trfp_pkg::COORD_W-1:0]  pos_y_r;
  logic                          last_r;

  logic [trfp_pkg::POS_W-1:0]    pos_cur;
  logic [trfp_pkg::POS_W-1:0]    pos_m1;
  logic [7:0]                    sum_base;
  logic                          rec_we;
  logic [trfp_pkg::SLOT_W-1:0]   wr_slot;
  logic [trfp_pkg::PART_W-1:0]   wr_part;
  logic [7:0]                    rd_hi, rd_xl, rd_yl;
  logic [trfp_pkg::CFG_W-1:0]    raw_x, raw_y;
  logic [PROD_W-1:0]             prod_x, prod_y;

  // byte bookkeeping
  assign pos_cur  = in_frame_start ? '0 : pos_r;
  assign pos_m1   = pos_cur - 1'b1;
  assign sum_base = (pos_cur == '0) ? 8'd0 : sum_r;
  assign wr_slot  = trfp_pkg::SLOT_W'(pos_m1 >> 2);
  assign wr_part  = pos_m1[trfp_pkg::PART_W-1:0];
  assign rec_we   = (pos_cur != '0) &&
                    (pos_cur <= trfp_pkg::POS_W'(4 * trfp_pkg::FINGER_SLOTS)) &&
                    (pos_m1[1:0] != 2'd3);

  assign sts.last_byte = (pos_cur == trfp_pkg::POS_W'(trfp_pkg::FRAME_LEN - 1));
  assign sts.mode_ok   = (mode_r == trfp_pkg::MODE_RAW);
  assign sts.sum_ok    = (8'(8'd0 - sum_base) == in_data_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      mode_r <= '0;
    end else if (cmd.take_byte) begin
      if (sts.last_byte) begin
        pos_r <= '0;
      end else begin
        pos_r <= pos_cur + 1'b1;
        sum_r <= sum_base + in_data_byte;
        if (pos_cur == '0) begin
          mode_r <= in_data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && !sts.last_byte && rec_we) begin
      rec_r[wr_slot][wr_part] <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pmx_r <= trfp_pkg::PANEL_RESET;
      pmy_r <= trfp_pkg::PANEL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == trfp_pkg::CFG_PANEL_X) begin
        pmx_r <= cfg_wdata;
      end
      if (cfg_index == trfp_pkg::CFG_PANEL_Y) begin
        pmy_r <= cfg_wdata;
      end
    end
  end

  // record scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.idx_clear) begin
      idx_r <= '0;
    end else if (cmd.idx_inc && !sts.idx_last) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign rd_hi = rec_r[idx_r][0];
  assign rd_xl = rec_r[idx_r][1];
  assign rd_yl = rec_r[idx_r][2];

  assign sts.rec_empty = (rd_hi == trfp_pkg::EMPTY_B) && (rd_xl == trfp_pkg::EMPTY_B) &&
                         (rd_yl == trfp_pkg::EMPTY_B);
  assign sts.idx_last  = (idx_r == trfp_pkg::SLOT_W'(trfp_pkg::FINGER_SLOTS - 1));

  assign raw_x  = {4'((rd_hi & trfp_pkg::HI_X_MASK) >> 4), rd_xl};
  assign raw_y  = {4'(rd_hi & trfp_pkg::HI_Y_MASK), rd_yl};
  assign prod_x = {{trfp_pkg::CFG_W{1'b0}}, raw_x} * {{trfp_pkg::CFG_W{1'b0}}, pmx_r};
  assign prod_y = {{trfp_pkg::CFG_W{1'b0}}, raw_y} * {{trfp_pkg::CFG_W{1'b0}}, pmy_r};

  // output register
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      kind_r <= cmd.load_kind;
      if (cmd.load_kind == trfp_pkg::KIND_FINGER) begin
        slot_r  <= trfp_pkg::OUT_SLOT_W'(idx_r);
        pos_x_r <= trfp_pkg::COORD_W'(prod_x >> trfp_pkg::RAW_SHIFT);
        pos_y_r <= trfp_pkg::COORD_W'(prod_y >> trfp_pkg::RAW_SHIFT);
        last_r  <= 1'b0;
      end else begin
        slot_r  <= '0;
        pos_x_r <= '0;
        pos_y_r <= '0;
        last_r  <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_slot  = slot_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_last  = last_r;

  a_pos_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_byte && sts.last_byte |=> pos_r == '0)
    else $error("position did not wrap after checksum byte");

  a_no_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_en && cmd.load_kind == trfp_pkg::KIND_FINGER |-> !sts.rec_empty)
    else $error("finger report loaded from an empty record");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= trfp_pkg::POS_W'(trfp_pkg::FRAME_LEN - 1))
    else $error("byte position past end of frame");

endmodule

### src/touch_report_frame_parser_top.sv
`timescale 1ns / 1ps

// Port group | Direction | Handshake          | Payload
// in_*       | input     | in_valid/in_stall  | data_byte[7:0], frame_start
// out_*      | output    | out_valid/out_stall| kind[1:0], slot[2:0], pos_x/pos_y[15:0], last
// cfg_*      | input     | cfg_we             | index[0], wdata[11:0]
//
// A byte inside a frame is taken while in_stall is low and causes no transfer.
// A good checksum byte starts a scan of one record slot per cycle (a full slot
// waits while the output is stalled), then a frame-done result; else a status result.
// in_stall is high while the scan or a status result is in progress.
// rst_n is synchronous; it clears position, sum, mode and sets both panel sizes to 2047.
// A stalled result holds in the output register; the scan waits on it for a non-empty record.

module touch_report_frame_parser_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_kind,
  output logic [trfp_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic [trfp_pkg::COORD_W-1:0]       out_pos_x,
  output logic [trfp_pkg::COORD_W-1:0]       out_pos_y,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [trfp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trfp_pkg::CFG_W-1:0]         cfg_wdata
);

  trfp_pkg::cmd_t cmd;
  trfp_pkg::sts_t sts;

  trfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  trfp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_slot       (out_slot),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_last       (out_last)
  );

endmodule
